// ===== rtl/casr_pkg.sv =====
// Shared command codes, node attribute type and constants for the route engine.
`timescale 1ns / 1ps

package casr_pkg;

  localparam int VW = 17;                       // capacity and load width
  localparam logic [VW-1:0] CAP_DEFAULT = 17'd99999;
  localparam logic [VW-1:0] VAL_MAX     = 17'd131071;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_CAP     = 3'd1;
  localparam logic [2:0] CMD_BLOCK   = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK = 3'd3;
  localparam logic [2:0] CMD_ROUTE   = 3'd4;

  typedef struct packed {
    logic          busy;
    logic [VW-1:0] cap;
    logic [VW-1:0] load;
  } node_attr_t;

endpackage

// ===== rtl/capacity_aware_shortest_route.sv =====
// Top level: graph store, Dijkstra sequencer and load-aware path emitter.
// Sequencing: edge add reads node a, then node b, then writes both adjacency slots;
//   capacity/block/unblock read then write the node entry; a route query scans all
//   nodes per extracted node, then reads each neighbor slot, walks the path and emits
//   each result, paced by the one-read-per-cycle distance memory and the node table port.
// Throughput: one request at a time; a new request is taken once the last one ends.
// Reset: control state clears; node table entries read as reset values until written.
`timescale 1ns / 1ps

module capacity_aware_shortest_route
  import casr_pkg::*;
#(
  parameter int NODES  = 16,
  parameter int DEGREE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_node_a,
  input  logic [3:0]  in_node_b,
  input  logic [7:0]  in_weight,
  input  logic [16:0] in_cap_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_path_node,
  output logic        out_found,
  output logic        out_last
);

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(DEGREE+1);
  localparam int AW = $clog2(NODES*DEGREE);
  localparam int LW = $clog2(NODES+1);
  localparam int DW = NW + 9;              // covers any simple path length

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_ND_MOD = 5'd2;
  localparam logic [4:0] S_ED_B   = 5'd3;
  localparam logic [4:0] S_ED_CHK = 5'd4;
  localparam logic [4:0] S_ED_W2  = 5'd5;
  localparam logic [4:0] S_RT_INI = 5'd6;
  localparam logic [4:0] S_SCAN   = 5'd7;
  localparam logic [4:0] S_UOPEN  = 5'd8;
  localparam logic [4:0] S_NB     = 5'd9;
  localparam logic [4:0] S_NB2    = 5'd10;
  localparam logic [4:0] S_NB3    = 5'd11;
  localparam logic [4:0] S_WALK   = 5'd12;
  localparam logic [4:0] S_WAIT   = 5'd13;
  localparam logic [4:0] S_O1     = 5'd14;
  localparam logic [4:0] S_O2     = 5'd15;
  localparam logic [4:0] S_O3     = 5'd16;
  localparam logic [4:0] S_EMIT0  = 5'd17;

  logic [4:0] state_r, state_nxt;

  // latched request
  logic [2:0]    cmd_r;
  logic [3:0]    a_r, b_r;
  logic [7:0]    w_r;
  logic [VW-1:0] capv_r;

  // add-edge scratch
  logic [CW-1:0] cnta_r, slotb_r;
  node_attr_t    attra_r, attrb_r;

  // Dijkstra scratch: flags live in flops, distance/parent in rm_* memory
  logic [NODES-1:0] reached_r, done_r, hasp_r;
  logic [NW:0]      sc_r;
  logic             pv_r, any_r;
  logic [NW-1:0]    pidx_r, best_r, u_r, v_r;
  logic [DW-1:0]    best_d_r, du_r, nd_r;
  logic [CW-1:0]    cntu_r, k_r;

  // path walk and emit
  logic [NW-1:0] cur_r, pos_r, n_r;
  logic [LW-1:0] len_r;

  // output register
  logic       out_valid_r, out_found_r, out_last_r;
  logic [3:0] out_node_r;

  // node table port
  logic          node_re, node_we;
  logic [NW-1:0] node_raddr, node_waddr;
  logic [CW-1:0] node_wcnt, rd_cnt;
  node_attr_t    node_wattr, rd_attr;

  // adjacency memory: {neighbor, weight}
  logic [NW+7:0] adj_mem [NODES*DEGREE];
  logic [NW+7:0] adj_q_r, adj_wdata;
  logic          adj_re, adj_we;
  logic [AW-1:0] adj_raddr, adj_waddr;

  // route memory: {distance, parent}
  logic [DW+NW-1:0] rm_mem [NODES];
  logic [DW+NW-1:0] rm_q_r, rm_wdata;
  logic             rm_re, rm_we;
  logic [NW-1:0]    rm_raddr, rm_waddr;
  logic [DW-1:0]    rm_dist_q;
  logic [NW-1:0]    rm_par_q;

  // path stack, pushed destination first
  logic [NW-1:0] stk_mem [NODES];
  logic [NW-1:0] stk_q_r;
  logic          stk_re, stk_we;

  logic          a_ok, b_ok, self_loop, edge_ok, rd_open, scan_hit, scan_end;
  logic          relax, out_free, walk_stop;
  logic [NW-1:0] a_idx, b_idx, adj_v_q;
  logic [7:0]    adj_w_q;
  logic [LW-1:0] len_inc;

  casr_node_tbl #(.NODES(NODES), .DEGREE(DEGREE)) u_node_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (node_re),
    .rd_addr (node_raddr),
    .rd_cnt  (rd_cnt),
    .rd_attr (rd_attr),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_cnt  (node_wcnt),
    .wr_attr (node_wattr)
  );

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) adj_q_r <= adj_mem[adj_raddr];
    if (rm_we) rm_mem[rm_waddr] <= rm_wdata;
    if (rm_re) rm_q_r <= rm_mem[rm_raddr];
    if (stk_we) stk_mem[len_r[NW-1:0]] <= cur_r;
    if (stk_re) stk_q_r <= stk_mem[pos_r];
  end

  assign {rm_dist_q, rm_par_q} = rm_q_r;
  assign {adj_v_q, adj_w_q}    = adj_q_r;

  assign a_ok      = {28'd0, a_r} < 32'(NODES);
  assign b_ok      = {28'd0, b_r} < 32'(NODES);
  assign a_idx     = NW'(a_r);
  assign b_idx     = NW'(b_r);
  assign self_loop = (a_r == b_r);
  // a self loop takes two slots of one list; rd_cnt holds node b here
  assign edge_ok   = self_loop ? (32'(cnta_r) + 32'd2 <= 32'(DEGREE))
                               : (32'(cnta_r) < 32'(DEGREE) && 32'(rd_cnt) < 32'(DEGREE));
  assign rd_open   = !rd_attr.busy && (rd_attr.load < rd_attr.cap);
  // smallest distance first; strict compare keeps the lower node on ties
  assign scan_hit  = pv_r && reached_r[pidx_r] && !done_r[pidx_r] &&
                     (!any_r || rm_dist_q < best_d_r);
  assign scan_end  = (sc_r == (NW+1)'(NODES)) && !pv_r;
  assign relax     = rd_open && (!reached_r[v_r] || nd_r < rm_dist_q);
  assign out_free  = !out_valid_r || out_ready;
  assign len_inc   = len_r + 1'b1;
  assign walk_stop = !hasp_r[cur_r] || (32'(len_inc) >= 32'(NODES));

  always_comb begin
    state_nxt  = state_r;
    node_re    = 1'b0;
    node_raddr = a_idx;
    node_we    = 1'b0;
    node_waddr = a_idx;
    node_wcnt  = rd_cnt;
    node_wattr = rd_attr;
    adj_re     = 1'b0;
    adj_raddr  = AW'(AW'(u_r) * AW'(DEGREE) + AW'(k_r));
    adj_we     = 1'b0;
    adj_waddr  = AW'(AW'(a_idx) * AW'(DEGREE) + AW'(cnta_r));
    adj_wdata  = {b_idx, w_r};
    rm_re      = 1'b0;
    rm_raddr   = sc_r[NW-1:0];
    rm_we      = 1'b0;
    rm_waddr   = v_r;
    rm_wdata   = {nd_r, u_r};
    stk_re     = 1'b0;
    stk_we     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (cmd_r)
          CMD_ADD: begin
            node_re   = a_ok && b_ok;
            state_nxt = (a_ok && b_ok) ? S_ED_B : S_IDLE;
          end
          CMD_CAP, CMD_BLOCK, CMD_UNBLOCK: begin
            node_re   = a_ok;
            state_nxt = a_ok ? S_ND_MOD : S_IDLE;
          end
          CMD_ROUTE: state_nxt = (a_ok && b_ok) ? S_RT_INI : S_EMIT0;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_ND_MOD: begin
        node_we = 1'b1;
        unique case (cmd_r)
          CMD_CAP:   node_wattr.cap  = capv_r;
          CMD_BLOCK: node_wattr.busy = 1'b1;
          default: begin
            node_wattr.busy = 1'b0;
            node_wattr.load = '0;
          end
        endcase
        state_nxt = S_IDLE;
      end
      S_ED_B: begin
        node_re    = 1'b1;
        node_raddr = b_idx;
        state_nxt  = S_ED_CHK;
      end
      S_ED_CHK: begin
        if (edge_ok) begin
          adj_we     = 1'b1;
          node_we    = 1'b1;
          node_wcnt  = cnta_r + 1'b1;
          node_wattr = attra_r;
          state_nxt  = S_ED_W2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ED_W2: begin
        adj_we     = 1'b1;
        adj_waddr  = AW'(AW'(b_idx) * AW'(DEGREE) + AW'(slotb_r));
        adj_wdata  = {a_idx, w_r};
        node_we    = 1'b1;
        node_waddr = b_idx;
        node_wcnt  = slotb_r + 1'b1;
        node_wattr = attrb_r;
        state_nxt  = S_IDLE;
      end
      S_RT_INI: begin
        rm_we     = 1'b1;
        rm_waddr  = a_idx;
        rm_wdata  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rm_re = (sc_r != (NW+1)'(NODES));
        if (scan_end) begin
          if (any_r) begin
            node_re    = 1'b1;
            node_raddr = best_r;
            state_nxt  = S_UOPEN;
          end else begin
            state_nxt = reached_r[b_idx] ? S_WALK : S_EMIT0;
          end
        end
      end
      S_UOPEN: state_nxt = rd_open ? S_NB : S_SCAN;
      S_NB: begin
        adj_re    = (k_r < cntu_r);
        state_nxt = (k_r < cntu_r) ? S_NB2 : S_SCAN;
      end
      S_NB2: begin
        node_re    = 1'b1;
        node_raddr = adj_v_q;
        rm_re      = 1'b1;
        rm_raddr   = adj_v_q;
        state_nxt  = S_NB3;
      end
      S_NB3: begin
        rm_we     = relax;
        state_nxt = S_NB;
      end
      S_WALK: begin
        stk_we = 1'b1;
        if (walk_stop) begin
          state_nxt = S_O1;
        end else begin
          rm_re     = 1'b1;
          rm_raddr  = cur_r;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_WALK;
      S_O1: begin
        stk_re    = 1'b1;
        state_nxt = S_O2;
      end
      S_O2: begin
        node_re    = 1'b1;
        node_raddr = stk_q_r;
        state_nxt  = S_O3;
      end
      S_O3: begin
        node_waddr = n_r;
        if (out_free) begin
          node_we         = 1'b1;
          node_wattr.load = (rd_attr.load == VAL_MAX) ? rd_attr.load : rd_attr.load + 1'b1;
          state_nxt       = (pos_r == '0) ? S_IDLE : S_O1;
        end
      end
      S_EMIT0: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reached_r   <= '0;
      done_r      <= '0;
      hasp_r      <= '0;
      pv_r        <= 1'b0;
      any_r       <= 1'b0;
      sc_r        <= '0;
      len_r       <= '0;
    end else begin
      state_r <= state_nxt;
      // a new result loads the register; otherwise a taken result empties it
      if ((state_r == S_O3 || state_r == S_EMIT0) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_RT_INI: begin
          reached_r <= {{(NODES-1){1'b0}}, 1'b1} << a_idx;
          done_r    <= '0;
          hasp_r    <= '0;
          sc_r      <= '0;
          pv_r      <= 1'b0;
          any_r     <= 1'b0;
        end
        S_SCAN: begin
          if (scan_hit) any_r <= 1'b1;
          if (sc_r != (NW+1)'(NODES)) begin
            sc_r <= sc_r + 1'b1;
            pv_r <= 1'b1;
          end else begin
            pv_r <= 1'b0;
          end
          if (scan_end) begin
            len_r <= '0;
            if (any_r) done_r[best_r] <= 1'b1;
          end
        end
        S_UOPEN, S_NB: begin
          if (state_nxt == S_SCAN) begin
            sc_r  <= '0;
            pv_r  <= 1'b0;
            any_r <= 1'b0;
          end
        end
        S_NB3: begin
          if (relax) begin
            reached_r[v_r] <= 1'b1;
            hasp_r[v_r]    <= 1'b1;
          end
        end
        S_WALK: len_r <= len_inc;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r  <= in_command;
        a_r    <= in_node_a;
        b_r    <= in_node_b;
        w_r    <= in_weight;
        capv_r <= in_cap_value;
      end
      S_ED_B: begin
        cnta_r  <= rd_cnt;
        attra_r <= rd_attr;
      end
      S_ED_CHK: begin
        slotb_r <= self_loop ? cnta_r + 1'b1 : rd_cnt;
        attrb_r <= self_loop ? attra_r : rd_attr;
      end
      S_SCAN: begin
        pidx_r <= sc_r[NW-1:0];
        if (scan_hit) begin
          best_r   <= pidx_r;
          best_d_r <= rm_dist_q;
        end
        if (scan_end) begin
          u_r   <= best_r;
          du_r  <= best_d_r;
          cur_r <= b_idx;
        end
      end
      S_UOPEN: begin
        cntu_r <= rd_cnt;
        k_r    <= '0;
      end
      S_NB2: begin
        v_r  <= adj_v_q;
        nd_r <= du_r + DW'(adj_w_q);
      end
      S_NB3: k_r <= k_r + 1'b1;
      S_WALK: begin
        if (walk_stop) pos_r <= len_r[NW-1:0];
      end
      S_WAIT: cur_r <= rm_par_q;
      S_O2: n_r <= stk_q_r;
      S_O3: begin
        if (out_free) begin
          out_node_r  <= 4'(n_r);
          out_found_r <= 1'b1;
          out_last_r  <= (pos_r == '0);
          pos_r       <= pos_r - 1'b1;
        end
      end
      S_EMIT0: begin
        if (out_free) begin
          out_node_r  <= '0;
          out_found_r <= 1'b0;
          out_last_r  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_path_node = out_node_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

  // a node is only finalized after it was reached
  a_done_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & ~reached_r) == '0)
    else $error("finalized node never reached");

  // a parent link is recorded only together with reaching
  a_parent_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (hasp_r & ~reached_r) == '0)
    else $error("parent set on unreached node");

  // a not-found result always closes its query
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_last_r)
    else $error("not-found result without last");

  // the walked path never exceeds the node count
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(NODES))
    else $error("path length overflow");

endmodule

// ===== rtl/casr_node_tbl.sv =====
// Per-node table: neighbor count, busy flag, capacity and load, with valid bits.
`timescale 1ns / 1ps

module casr_node_tbl
  import casr_pkg::*;
#(
  parameter int NODES  = 16,
  parameter int DEGREE = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(NODES)-1:0]     rd_addr,
  output logic [$clog2(DEGREE+1)-1:0]  rd_cnt,
  output node_attr_t                   rd_attr,
  input  logic                         wr_en,
  input  logic [$clog2(NODES)-1:0]     wr_addr,
  input  logic [$clog2(DEGREE+1)-1:0]  wr_cnt,
  input  node_attr_t                   wr_attr
);

  localparam int CW = $clog2(DEGREE+1);

  logic [CW-1:0] cnt_mem  [NODES];
  node_attr_t    attr_mem [NODES];
  logic [NODES-1:0] vld_r;
  logic          q_vld_r;
  logic [CW-1:0] q_cnt_r;
  node_attr_t    q_attr_r;
  node_attr_t    attr_reset;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr]  <= wr_cnt;
      attr_mem[wr_addr] <= wr_attr;
    end
    if (rd_en) begin
      q_cnt_r  <= cnt_mem[rd_addr];
      q_attr_r <= attr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) q_vld_r <= vld_r[rd_addr];
    end
  end

  // never-written entries read back as the reset values
  always_comb begin
    attr_reset.busy = 1'b0;
    attr_reset.cap  = CAP_DEFAULT;
    attr_reset.load = '0;
    rd_cnt  = q_vld_r ? q_cnt_r : '0;
    rd_attr = q_vld_r ? q_attr_r : attr_reset;
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the capacity-aware shortest route engine.
`timescale 1ns / 1ps

module tb_top
  import casr_pkg::*;
;

  localparam int N_NODES  = 16;
  localparam int N_SLOTS  = 8;
  localparam int DRAIN_CYCLES = 3000;  // longest route query plus margin

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_ADD;
  logic [3:0]  in_node_a = '0;
  logic [3:0]  in_node_b = '0;
  logic [7:0]  in_weight = '0;
  logic [16:0] in_cap_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_path_node;
  logic        out_found;
  logic        out_last;

  capacity_aware_shortest_route dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .in_weight(in_weight), .in_cap_value(in_cap_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_path_node(out_path_node), .out_found(out_found), .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One expected route hop.
  typedef struct packed {
    logic [3:0] node;
    logic       found;
    logic       last;
  } hop_t;

  hop_t hop_q[$];
  int   err_cnt = 0;

  // Shadow copy of the graph and node table.
  int unsigned   deg_cnt [N_NODES];
  logic [3:0]    nbr_id  [N_NODES][N_SLOTS];
  logic [7:0]    nbr_wt  [N_NODES][N_SLOTS];
  logic          blocked [N_NODES];
  logic [VW-1:0] cap_tbl [N_NODES];
  logic [VW-1:0] load_tbl[N_NODES];

  function automatic bit node_usable(int n);
    return !blocked[n] && (load_tbl[n] < cap_tbl[n]);
  endfunction

  task automatic shadow_reset();
    for (int i = 0; i < N_NODES; i++) begin
      deg_cnt[i] = 0;
      blocked[i] = 1'b0;
      cap_tbl[i] = CAP_DEFAULT;
      load_tbl[i] = '0;
    end
  endtask

  task automatic append_slot(int n, int other, logic [7:0] w);
    nbr_id[n][deg_cnt[n]] = other[3:0];
    nbr_wt[n][deg_cnt[n]] = w;
    deg_cnt[n]++;
  endtask

  // Dijkstra on the shadow graph; queues expected hops and bumps loads.
  task automatic predict_route(int src, int dst);
    longint unsigned cost[N_NODES];
    int  parent[N_NODES];
    bit  seen[N_NODES], closed[N_NODES], linked[N_NODES];
    int  trail[N_NODES];
    int  len, cur, u, v;
    bit  any;
    longint unsigned nd;
    hop_t h;
    for (int i = 0; i < N_NODES; i++) begin
      cost[i] = 0; parent[i] = 0; seen[i] = 0; closed[i] = 0; linked[i] = 0;
    end
    seen[src] = 1;
    forever begin
      any = 0; u = 0;
      for (int i = 0; i < N_NODES; i++)
        if (seen[i] && !closed[i] && (!any || cost[i] < cost[u])) begin
          u = i; any = 1;
        end
      if (!any) break;
      closed[u] = 1;
      if (!node_usable(u)) continue;
      for (int k = 0; k < deg_cnt[u]; k++) begin
        v = nbr_id[u][k];
        nd = cost[u] + nbr_wt[u][k];
        if (!node_usable(v)) continue;
        if (!seen[v] || nd < cost[v]) begin
          cost[v] = nd; seen[v] = 1; parent[v] = u; linked[v] = 1;
        end
      end
    end
    if (!seen[dst]) begin
      h = '{node: 4'd0, found: 1'b0, last: 1'b1};
      hop_q.insert(hop_q.size(), h);
      return;
    end
    len = 0; cur = dst;
    forever begin
      trail[len] = cur;
      len++;
      if (!linked[cur] || len >= N_NODES) break;
      cur = parent[cur];
    end
    for (int i = 0; i < len; i++) begin
      cur = trail[len-1-i];
      if (load_tbl[cur] < VAL_MAX) load_tbl[cur]++;
      h = '{node: cur[3:0], found: 1'b1, last: (i == len-1)};
      hop_q.insert(hop_q.size(), h);
    end
  endtask

  // Apply one accepted request to the shadow model.
  task automatic model_request(logic [2:0] cmd, int a, int b, logic [7:0] w,
                               logic [16:0] cap);
    case (cmd)
      CMD_ADD: begin
        if (a == b) begin
          if (deg_cnt[a] + 2 <= N_SLOTS) begin
            append_slot(a, b, w); append_slot(b, a, w);
          end
        end else if (deg_cnt[a] < N_SLOTS && deg_cnt[b] < N_SLOTS) begin
          append_slot(a, b, w); append_slot(b, a, w);
        end
      end
      CMD_CAP:     cap_tbl[a] = cap;
      CMD_BLOCK:   blocked[a] = 1'b1;
      CMD_UNBLOCK: begin
        blocked[a] = 1'b0;
        load_tbl[a] = '0;
      end
      CMD_ROUTE:   predict_route(a, b);
      default: ;   // codes 5..7 are ignored
    endcase
  endtask

  // Sender gap control: bursts of random length, random gaps between.
  int burst_left = 0;

  task automatic send_request(logic [2:0] cmd, int a, int b, int w, int cap);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    // the engine is busy with each request it takes, so waiting here costs no throughput
    @(posedge clk);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_node_a    <= a[3:0];
    in_node_b    <= b[3:0];
    in_weight    <= w[7:0];
    in_cap_value <= cap[16:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Request taken at this edge; update the shadow before driving the next.
    model_request(cmd, a, b, w[7:0], cap[16:0]);
    in_valid <= 1'b0;
  endtask

  // Hold off until every expected hop has drained.
  task automatic wait_drained();
    while (hop_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: alternates free-run stretches and random stalls.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk);
        out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    hop_t exp_h;
    if (rst_n && out_valid && out_ready) begin
      if (hop_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result node=%0d found=%0b last=%0b",
                   out_path_node, out_found, out_last);
      end else begin
        exp_h = hop_q.pop_front();
        if (out_path_node !== exp_h.node || out_found !== exp_h.found ||
            out_last !== exp_h.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp node=%0d found=%0b last=%0b, got %0d %0b %0b",
                     exp_h.node, exp_h.found, exp_h.last,
                     out_path_node, out_found, out_last);
        end
      end
    end
  end

  // ---------------- directed tests ----------------

  // Field extremes, self loops, list overflow, unknown codes.
  task automatic test_graph_build();
    send_request(CMD_ADD, 0, 15, 255, 131071);
    send_request(CMD_ADD, 15, 15, 0, 0);      // self loop takes two slots
    send_request(CMD_ADD, 0, 1, 0, 0);
    send_request(CMD_ADD, 1, 15, 1, 0);
    send_request(3'd5, 0, 0, 0, 0);
    send_request(3'd6, 15, 15, 255, 131071);
    send_request(3'd7, 3, 4, 9, 9);
    send_request(CMD_ROUTE, 0, 15, 0, 0);     // picks cheaper 0-1-15
    send_request(CMD_ROUTE, 15, 15, 0, 0);    // start equals destination
    send_request(CMD_ROUTE, 0, 7, 0, 0);      // unreachable
    // Fill node 2's list, then overflow it.
    for (int i = 0; i < 9; i++) send_request(CMD_ADD, 2, 3 + (i % 4), i, 0);
    send_request(CMD_ADD, 14, 14, 5, 0);
    send_request(CMD_ROUTE, 2, 6, 0, 0);
  endtask

  // Busy and full nodes, unblock clearing load, capacity extremes.
  task automatic test_capacity_block();
    send_request(CMD_BLOCK, 1, 0, 0, 0);
    send_request(CMD_ROUTE, 0, 15, 0, 0);     // detours through direct edge
    send_request(CMD_ROUTE, 1, 1, 0, 0);      // busy start equals destination
    send_request(CMD_ROUTE, 1, 0, 0, 0);      // busy start: unreachable
    send_request(CMD_UNBLOCK, 1, 0, 0, 0);
    send_request(CMD_CAP, 0, 0, 0, 0);        // node 0 now full
    send_request(CMD_ROUTE, 0, 15, 0, 0);
    send_request(CMD_CAP, 0, 0, 0, 131071);
    send_request(CMD_CAP, 3, 0, 0, 1);
    send_request(CMD_ROUTE, 2, 3, 0, 0);
    send_request(CMD_ROUTE, 2, 3, 0, 0);      // 3 full after one use
    send_request(CMD_UNBLOCK, 3, 0, 0, 0);
    // Hold the sender until all hops are back.
    wait_drained();
  endtask

  // Random mix: mostly edge building and routes, some attribute changes and unknown codes.
  task automatic test_random_mix(int n_items);
    int sel, a, b;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      a = $urandom_range(0, 15);
      b = $urandom_range(0, 15);
      if (sel < 35)
        send_request(CMD_ADD, a, b, $urandom_range(0, 255), 0);
      else if (sel < 75)
        send_request(CMD_ROUTE, a, b, $urandom, $urandom);
      else if (sel < 83)
        send_request(CMD_CAP, a, b, $urandom,
                     ($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 131071)));
      else if (sel < 89)
        send_request(CMD_BLOCK, a, b, $urandom, $urandom);
      else if (sel < 96)
        send_request(CMD_UNBLOCK, a, b, $urandom, $urandom);
      else
        send_request(3'($urandom_range(5, 7)), a, b, $urandom, $urandom);
    end
  endtask

  initial begin
    shadow_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_graph_build();
    test_capacity_block();
    test_random_mix(78);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && hop_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
